[rtl/mqbt_pkg.sv]
// shared constants, command and status types for the bezier tessellator
package mqbt_pkg;

  localparam int STEP_LOG2   = 4;
  localparam int COORD_WIDTH = 16;

  localparam int N_STEPS   = 1 << STEP_LOG2;
  localparam int K_W       = STEP_LOG2 + 1;
  localparam int ACC_W     = COORD_WIDTH + 2 * STEP_LOG2 + 6;
  localparam int RND_SHIFT = 2 * STEP_LOG2 + 1;
  localparam int RES_W     = ACC_W - RND_SHIFT;
  localparam int DATA_W    = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int USER_W    = 2;

  localparam logic signed [RES_W-1:0] RES_MAX =
    RES_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(N_STEPS * N_STEPS);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   coord2_t;

  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_CLEAR = 3'd1;
  localparam op_t OP_FIRST = 3'd2;
  localparam op_t OP_VIA   = 3'd3;
  localparam op_t OP_INNER = 3'd4;
  localparam op_t OP_LAST  = 3'd5;

  typedef struct packed {
    logic load;
    op_t  op;
    logic setup1;
    logic setup2;
    logic step;
    logic step_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/mqbt_datapath.sv]
// point state, forward-difference evaluator and output register
module mqbt_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mqbt_pkg::dp_cmd_t                     cmd_i,
  output mqbt_pkg::dp_stat_t                    stat_o,
  input  mqbt_pkg::coord_t                      point_x_i,
  input  mqbt_pkg::coord_t                      point_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output mqbt_pkg::coord_t                      curve_x_o,
  output mqbt_pkg::coord_t                      curve_y_o,
  output logic                                  last_sample_o,
  output logic                                  curve_done_o,
  output logic                                  clipped_o
);

  localparam int AW = mqbt_pkg::ACC_W;
  localparam int CW = mqbt_pkg::COORD_WIDTH;

  // round to nearest and saturate, result is {clip, coord}
  function automatic logic [CW:0] sat_sample(input logic signed [AW-1:0] p);
    logic signed [AW-1:0]               sum;
    logic signed [mqbt_pkg::RES_W-1:0]  r;
    logic [CW:0]                        res;
    sum = p + mqbt_pkg::RND_BIAS;
    r   = mqbt_pkg::RES_W'(sum >>> mqbt_pkg::RND_SHIFT);
    if (r > mqbt_pkg::RES_MAX) begin
      res = {1'b1, mqbt_pkg::RES_MAX[CW-1:0]};
    end else if (r < mqbt_pkg::RES_MIN) begin
      res = {1'b1, mqbt_pkg::RES_MIN[CW-1:0]};
    end else begin
      res = {1'b0, r[CW-1:0]};
    end
    return res;
  endfunction

  mqbt_pkg::coord_t  pt [2];
  mqbt_pkg::coord2_t start_q [2];
  mqbt_pkg::coord2_t start_d [2];
  mqbt_pkg::coord_t  via_q [2];
  mqbt_pkg::coord_t  via_d [2];

  mqbt_pkg::coord2_t s2_q [2];
  mqbt_pkg::coord_t  v_q  [2];
  mqbt_pkg::coord2_t e2_q [2];
  logic              done_q;

  logic signed [AW-1:0] c4_q [2];
  logic signed [AW-1:0] b_q  [2];
  logic signed [AW-1:0] p_q  [2];
  logic signed [AW-1:0] d_q  [2];

  logic signed [AW-1:0] sum_se [2];
  logic signed [AW-1:0] v8     [2];
  logic signed [AW-1:0] a_val  [2];
  mqbt_pkg::coord2_t    mid    [2];
  logic [CW:0]          smp    [2];

  logic              out_valid_q;
  mqbt_pkg::coord_t  out_x_q;
  mqbt_pkg::coord_t  out_y_q;
  logic              out_last_q;
  logic              out_done_q;
  logic              out_clip_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mid[i]    = mqbt_pkg::coord2_t'(via_q[i]) + mqbt_pkg::coord2_t'(pt[i]);
      sum_se[i] = AW'(s2_q[i]) + AW'(e2_q[i]);
      v8[i]     = AW'(v_q[i]) <<< 3;
      a_val[i]  = (c4_q[i] - (AW'(s2_q[i]) <<< 1)) <<< mqbt_pkg::STEP_LOG2;
      smp[i]    = sat_sample(p_q[i]);
    end
  end

  // state update at point transfer
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      start_d[i] = start_q[i];
      via_d[i]   = via_q[i];
      if (cmd_i.load) begin
        case (cmd_i.op)
          mqbt_pkg::OP_CLEAR, mqbt_pkg::OP_LAST: begin
            start_d[i] = '0;
            via_d[i]   = '0;
          end
          mqbt_pkg::OP_FIRST: begin
            start_d[i] = mqbt_pkg::coord2_t'(pt[i]) <<< 1;
            via_d[i]   = pt[i];
          end
          mqbt_pkg::OP_VIA: begin
            via_d[i] = pt[i];
          end
          mqbt_pkg::OP_INNER: begin
            start_d[i] = mid[i];
            via_d[i]   = pt[i];
          end
          default: begin
            start_d[i] = start_q[i];
            via_d[i]   = via_q[i];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        start_q[i] <= '0;
        via_q[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < 2; i++) begin
        start_q[i] <= start_d[i];
        via_q[i]   <= via_d[i];
      end
    end
  end

  // segment operands and difference engine
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      done_q <= (cmd_i.op == mqbt_pkg::OP_LAST);
      for (int i = 0; i < 2; i++) begin
        s2_q[i] <= start_q[i];
        v_q[i]  <= via_q[i];
        e2_q[i] <= (cmd_i.op == mqbt_pkg::OP_LAST) ?
                   (mqbt_pkg::coord2_t'(pt[i]) <<< 1) : mid[i];
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd_i.setup1) begin
        c4_q[i] <= v8[i] - sum_se[i];
        b_q[i]  <= (sum_se[i] <<< 1) - v8[i];
      end
      if (cmd_i.setup2) begin
        p_q[i] <= AW'(s2_q[i]) <<< (2 * mqbt_pkg::STEP_LOG2);
        d_q[i] <= a_val[i] + b_q[i];
      end else if (cmd_i.step) begin
        p_q[i] <= p_q[i] + d_q[i];
        d_q[i] <= d_q[i] + (b_q[i] <<< 1);
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_x_q    <= smp[0][CW-1:0];
      out_y_q    <= smp[1][CW-1:0];
      out_clip_q <= smp[0][CW] | smp[1][CW];
      out_last_q <= cmd_i.step_last;
      out_done_q <= done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign curve_x_o     = out_x_q;
  assign curve_y_o     = out_y_q;
  assign last_sample_o = out_last_q;
  assign curve_done_o  = out_done_q;
  assign clipped_o     = out_clip_q;

endmodule

[rtl/mqbt_ctrl.sv]
// sequencer: point classification, setup and sample stepping
module mqbt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output mqbt_pkg::dp_cmd_t   cmd_o,
  input  mqbt_pkg::dp_stat_t  stat_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP1 = 2'd1;
  localparam logic [1:0] ST_SETUP2 = 2'd2;
  localparam logic [1:0] ST_RUN    = 2'd3;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  localparam logic [mqbt_pkg::K_W-1:0] K_LAST = mqbt_pkg::K_W'(mqbt_pkg::N_STEPS);

  logic [1:0]               state_q, state_d;
  logic [1:0]               seen_q, seen_d;
  logic [mqbt_pkg::K_W-1:0] k_q, k_d;
  logic                     in_xfer;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    k_d     = k_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          if (seen_q == SEEN_NONE) begin
            cmd_o.op = in_last_i ? mqbt_pkg::OP_CLEAR : mqbt_pkg::OP_FIRST;
            seen_d   = in_last_i ? SEEN_NONE : SEEN_ONE;
          end else if (in_last_i) begin
            cmd_o.op = mqbt_pkg::OP_LAST;
            seen_d   = SEEN_NONE;
            state_d  = ST_SETUP1;
          end else if (seen_q == SEEN_ONE) begin
            cmd_o.op = mqbt_pkg::OP_VIA;
            seen_d   = SEEN_TWO;
          end else begin
            cmd_o.op = mqbt_pkg::OP_INNER;
            state_d  = ST_SETUP1;
          end
        end
      end
      ST_SETUP1: begin
        cmd_o.setup1 = 1'b1;
        state_d      = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd_o.setup2 = 1'b1;
        k_d          = '0;
        state_d      = ST_RUN;
      end
      ST_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.step      = 1'b1;
          cmd_o.step_last = (k_q == K_LAST);
          k_d             = k_q + mqbt_pkg::K_W'(1);
          if (k_q == K_LAST) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= SEEN_NONE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      k_q     <= k_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> k_q <= K_LAST)
    else $error("sample index past end of segment");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && cmd_o.step_last |=>
      state_q == ST_IDLE && k_q == K_LAST + mqbt_pkg::K_W'(1))
    else $error("segment did not end after final sample");

  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("point count out of range");

  a_seg_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load && (cmd_o.op == mqbt_pkg::OP_LAST || cmd_o.op == mqbt_pkg::OP_INNER)
    |=> state_q == ST_SETUP1)
    else $error("segment point did not start setup");

  a_step_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> state_q == ST_RUN && stat_i.out_free)
    else $error("sample issued without room in output register");
`endif

endmodule

[rtl/midpoint_quadratic_bezier_tessellator_core.sv]
// top level: midpoint quadratic bezier tessellator core
// Points of a polyline arrive one per transfer on the slave stream, with tlast marking the
// final point; each point after the second (and the final point of any polyline of two or
// more points) produces one quadratic segment of 2^STEP_LOG2+1 samples on the master stream,
// 17 at the default setting, with tlast on the final sample of each segment. A point that
// makes no segment leaves the input ready. A segment point holds off the next point until
// its segment is done: two setup states set up the curve's difference terms, then
// one sample per cycle comes from a forward-difference adder per axis,
// slower only while the output register is held by tready low.
module midpoint_quadratic_bezier_tessellator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_x, point_y
  input  logic [mqbt_pkg::DATA_W-1:0]          s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // curve_x, curve_y
  output logic [mqbt_pkg::DATA_W-1:0]          m_axis_tdata,
  output logic                                 m_axis_tlast,
  // curve_done, clipped
  output logic [mqbt_pkg::USER_W-1:0]          m_axis_tuser
);

  localparam int CW = mqbt_pkg::COORD_WIDTH;

  mqbt_pkg::dp_cmd_t  cmd;
  mqbt_pkg::dp_stat_t stat;
  mqbt_pkg::coord_t   point_x;
  mqbt_pkg::coord_t   point_y;
  mqbt_pkg::coord_t   curve_x;
  mqbt_pkg::coord_t   curve_y;
  logic               curve_done;
  logic               clipped;

  assign point_x = s_axis_tdata[CW-1:0];
  assign point_y = s_axis_tdata[2*CW-1:CW];

  mqbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mqbt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .curve_x_o     (curve_x),
    .curve_y_o     (curve_y),
    .last_sample_o (m_axis_tlast),
    .curve_done_o  (curve_done),
    .clipped_o     (clipped)
  );

  assign m_axis_tdata = mqbt_pkg::DATA_W'({curve_y, curve_x});
  assign m_axis_tuser = {clipped, curve_done};

endmodule

[dv/mqbt_sample_checker.sv]
// checker for the bezier tessellator: predicts curve samples per point and compares them
`timescale 1ns / 100ps

module mqbt_sample_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pt_valid_i,
  input  logic                        pt_ready_i,
  // point_x, point_y
  input  logic [mqbt_pkg::DATA_W-1:0] pt_data_i,
  input  logic                        pt_last_i,
  input  logic                        smp_valid_i,
  input  logic                        smp_ready_i,
  // curve_x, curve_y
  input  logic [mqbt_pkg::DATA_W-1:0] smp_data_i,
  input  logic                        smp_last_i,
  // curve_done, clipped
  input  logic [mqbt_pkg::USER_W-1:0] smp_user_i,
  output int                          err_cnt_o,
  output int                          pending_o
);

  localparam int     CW       = mqbt_pkg::COORD_WIDTH;
  localparam longint COORD_HI = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  typedef struct packed {
    mqbt_pkg::coord_t x;
    mqbt_pkg::coord_t y;
    logic             seg_end;
    logic             done;
    logic             clip;
  } curve_sample_t;

  curve_sample_t samples_due[$];

  mqbt_pkg::coord2_t origin_x2 = '0;
  mqbt_pkg::coord2_t origin_y2 = '0;
  mqbt_pkg::coord_t  via_x     = '0;
  mqbt_pkg::coord_t  via_y     = '0;
  int                points_held = 0;

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string what);
    err_cnt_o++;
    $display("%0t ns: %s", $time, what);
  endtask

  // sample numerator over 4*N^2, rounded half up by a floor shift
  function automatic longint bezier_coord(input longint s2, input longint v,
                                          input longint e2, input longint k);
    longint n;
    longint c4;
    longint num;
    n   = longint'(mqbt_pkg::N_STEPS);
    c4  = 8 * v - s2 - e2;
    num = 2 * (n - k) * (n - k) * s2 + 2 * k * (n - k) * c4 + 2 * k * k * e2;
    return (num + 2 * n * n) >>> (2 * mqbt_pkg::STEP_LOG2 + 2);
  endfunction

  function automatic mqbt_pkg::coord_t clamp_coord(input longint r, inout logic hit);
    if (r > COORD_HI) begin
      hit = 1'b1;
      return mqbt_pkg::coord_t'(COORD_HI);
    end
    if (r < COORD_LO) begin
      hit = 1'b1;
      return mqbt_pkg::coord_t'(COORD_LO);
    end
    return mqbt_pkg::coord_t'(r);
  endfunction

  task automatic emit_segment_samples(input longint end_x2, input longint end_y2,
                                      input logic closing);
    curve_sample_t s;
    for (int k = 0; k <= mqbt_pkg::N_STEPS; k++) begin
      s.clip    = 1'b0;
      s.x       = clamp_coord(bezier_coord(longint'(origin_x2), longint'(via_x),
                                           end_x2, longint'(k)), s.clip);
      s.y       = clamp_coord(bezier_coord(longint'(origin_y2), longint'(via_y),
                                           end_y2, longint'(k)), s.clip);
      s.seg_end = (k == mqbt_pkg::N_STEPS);
      s.done    = closing;
      samples_due = {samples_due, s};
    end
  endtask

  task automatic clear_polyline();
    origin_x2   = '0;
    origin_y2   = '0;
    via_x       = '0;
    via_y       = '0;
    points_held = 0;
  endtask

  task automatic take_point(input mqbt_pkg::coord_t px, input mqbt_pkg::coord_t py,
                            input logic lst);
    longint mx2;
    longint my2;
    if (points_held == 0) begin
      if (lst) begin
        clear_polyline();
      end else begin
        origin_x2   = mqbt_pkg::coord2_t'(2 * longint'(px));
        origin_y2   = mqbt_pkg::coord2_t'(2 * longint'(py));
        via_x       = px;
        via_y       = py;
        points_held = 1;
      end
    end else if (lst) begin
      emit_segment_samples(2 * longint'(px), 2 * longint'(py), 1'b1);
      clear_polyline();
    end else if (points_held == 1) begin
      via_x       = px;
      via_y       = py;
      points_held = 2;
    end else begin
      mx2 = longint'(via_x) + longint'(px);
      my2 = longint'(via_y) + longint'(py);
      emit_segment_samples(mx2, my2, 1'b0);
      origin_x2 = mqbt_pkg::coord2_t'(mx2);
      origin_y2 = mqbt_pkg::coord2_t'(my2);
      via_x     = px;
      via_y     = py;
    end
  endtask

  task automatic check_sample();
    curve_sample_t got;
    curve_sample_t want;
    got.x       = smp_data_i[CW-1:0];
    got.y       = smp_data_i[2*CW-1:CW];
    got.seg_end = smp_last_i;
    got.done    = smp_user_i[0];
    got.clip    = smp_user_i[1];
    if (samples_due.size() == 0) begin
      report_mismatch($sformatf("sample x=%0d y=%0d with nothing due", got.x, got.y));
      return;
    end
    want = samples_due.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.seg_end !== want.seg_end ||
        got.done !== want.done || got.clip !== want.clip) begin
      report_mismatch($sformatf(
        {"sample got x=%0d y=%0d last=%b done=%b clip=%b, ",
         "want x=%0d y=%0d last=%b done=%b clip=%b"},
        got.x, got.y, got.seg_end, got.done, got.clip,
        want.x, want.y, want.seg_end, want.done, want.clip));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp_valid_i && smp_ready_i) check_sample();
      if (pt_valid_i && pt_ready_i) begin
        take_point(pt_data_i[CW-1:0], pt_data_i[2*CW-1:CW], pt_last_i);
      end
      pending_o = samples_due.size();
    end
  end

endmodule

[dv/tb_midpoint_quadratic_bezier_tessellator_core.sv]
// testbench top for the bezier tessellator: point stimulus, sample sink pacing and verdict
`timescale 1ns / 100ps

module tb_midpoint_quadratic_bezier_tessellator_core;

  localparam int               CW = mqbt_pkg::COORD_WIDTH;
  localparam mqbt_pkg::coord_t PT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam mqbt_pkg::coord_t PT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int               POINT_BUDGET = 180;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [mqbt_pkg::DATA_W-1:0] s_axis_tdata  = '0;
  logic                        s_axis_tlast  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [mqbt_pkg::DATA_W-1:0] m_axis_tdata;
  logic                        m_axis_tlast;
  logic [mqbt_pkg::USER_W-1:0] m_axis_tuser;

  int err_cnt;
  int pending;
  int points_sent = 0;
  int sink_stall;
  bit src_idle    = 1'b1;
  bit sink_idle   = 1'b1;

  always #6 clk_i = ~clk_i;

  midpoint_quadratic_bezier_tessellator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  mqbt_sample_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_valid_i  (s_axis_tvalid),
    .pt_ready_i  (s_axis_tready),
    .pt_data_i   (s_axis_tdata),
    .pt_last_i   (s_axis_tlast),
    .smp_valid_i (m_axis_tvalid),
    .smp_ready_i (m_axis_tready),
    .smp_data_i  (m_axis_tdata),
    .smp_last_i  (m_axis_tlast),
    .smp_user_i  (m_axis_tuser),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  // sample sink: random stall before each transfer while sink_idle is set
  always begin
    @(negedge clk_i);
    sink_stall = sink_idle ? $urandom_range(0, 16) : 0;
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      repeat (sink_stall) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
    @(posedge clk_i);
    while (!m_axis_tvalid) @(posedge clk_i);
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_point(input mqbt_pkg::coord_t px, input mqbt_pkg::coord_t py,
                            input logic lst);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mqbt_pkg::DATA_W'({py, px});
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    points_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_samples();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_random_polyline();
    int               len;
    bit               wide;
    mqbt_pkg::coord_t px;
    mqbt_pkg::coord_t py;
    len  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
    wide = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if (wide || $urandom_range(0, 5) == 0) begin
        px = mqbt_pkg::coord_t'($urandom);
        py = mqbt_pkg::coord_t'($urandom);
      end else begin
        px = mqbt_pkg::coord_t'($urandom_range(0, 4095)) - mqbt_pkg::coord_t'(2048);
        py = mqbt_pkg::coord_t'($urandom_range(0, 4095)) - mqbt_pkg::coord_t'(2048);
      end
      send_point(px, py, i == len - 1);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single point polylines, zero and nonzero
    send_point('0, '0, 1'b1);
    send_point(-16'sd1234, 16'sd4321, 1'b1);
    // two point polyline
    send_point(16'sd160, -16'sd80, 1'b0);
    send_point(-16'sd480, 16'sd320, 1'b1);
    // three points, spanning both coordinate limits
    send_point(PT_MAX, PT_MIN, 1'b0);
    send_point(PT_MAX, PT_MIN, 1'b0);
    send_point(PT_MIN, PT_MAX, 1'b1);
    // inner points at alternating extremes
    send_point(PT_MIN, PT_MIN, 1'b0);
    send_point(PT_MAX, PT_MAX, 1'b0);
    send_point(PT_MIN, PT_MIN, 1'b0);
    send_point(PT_MAX, PT_MAX, 1'b0);
    send_point(PT_MIN, PT_MAX, 1'b1);
    // small values around zero, rounding ties
    send_point('0, '0, 1'b0);
    send_point(16'sd16, 16'sd32, 1'b0);
    send_point(16'sd48, 16'sd16, 1'b0);
    send_point(-16'sd1, -16'sd1, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);
    send_point(-16'sd16, '0, 1'b0);
    send_point('0, 16'sd16, 1'b0);
    send_point(16'sd16, '0, 1'b1);
    drain_samples();

    for (int n = 0; points_sent < POINT_BUDGET; n++) begin
      if (n % 6 == 0) begin
        src_idle  = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
      end
      if (n == 12) drain_samples();
      send_random_polyline();
    end

    drain_samples();
    repeat (40) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_midpoint_quadratic_bezier_tessellator_core: clean");
    end else begin
      $display("tb_midpoint_quadratic_bezier_tessellator_core: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_midpoint_quadratic_bezier_tessellator_core: errors");
    $finish;
  end

endmodule
